// File: hw/rtl/length_prefixed_frame_deframer_macros.svh
// Assertion macros for the frame deframer checker.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_MACROS_SVH

// Check while out of reset.
`define LPFD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check at every edge, reset included.
`define LPFD_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: hw/rtl/lpfd_pkg.sv
package lpfd_pkg;

  localparam logic [7:0]  ByteDollar     = 8'h24;
  localparam logic [7:0]  ByteHash       = 8'h23;
  localparam logic [7:0]  ByteTilde      = 8'h7E;
  localparam logic [7:0]  ByteZero       = 8'h30;
  localparam logic [7:0]  ByteNine       = 8'h39;
  localparam logic [15:0] MaxLengthReset = 16'd1024;
  localparam logic [15:0] FrameLenMax    = 16'hFFFF;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindAccept = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [4:0] {
    PhHunt    = 5'b00001,
    PhLen     = 5'b00010,
    PhSkip    = 5'b00100,
    PhPayload = 5'b01000,
    PhTail    = 5'b10000
  } phase_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [7:0]  data_byte;
    logic [15:0] frame_length;
  } result_t;

endpackage

// File: hw/rtl/lpfd_in_stage.sv
module lpfd_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] rx_byte_i,
  input  logic       advance_i,
  output logic       byte_valid_o,
  output logic [7:0] byte_o
);

  logic       vld_q, vld_d;
  logic [7:0] byte_q;
  logic       load;

  assign in_ready_o = !vld_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx_byte_i;
    end
  end

  assign byte_valid_o = vld_q;
  assign byte_o       = byte_q;

endmodule

// File: hw/rtl/lpfd_parser.sv
module lpfd_parser import lpfd_pkg::*; #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_max_length_i,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  output result_t     result_o
);

  localparam int unsigned AccW  = LEN_WIDTH + 1;
  localparam int unsigned SumW  = LEN_WIDTH + 5;
  localparam int unsigned WideW = (AccW > 17) ? AccW : 17;

  phase_e               phase_q, phase_d;
  logic                 pwm_q, pwm_d;
  logic                 fhs_q, fhs_d;
  logic                 tds_q, tds_d;
  logic [AccW-1:0]      accum_q, accum_d;
  logic [LEN_WIDTH-1:0] left_q, left_d;
  logic [15:0]          max_len_q;

  logic                 clear;
  logic                 is_digit;
  logic [SumW-1:0]      acc_x, digit_sum, limit_x;
  logic [WideW-1:0]     accum_wide, max_wide;
  logic [15:0]          sat_len;

  assign is_digit   = (byte_i >= ByteZero) && (byte_i <= ByteNine);
  assign acc_x      = SumW'(accum_q);
  assign limit_x    = SumW'(1) << LEN_WIDTH;
  assign digit_sum  = (acc_x << 3) + (acc_x << 1) + SumW'(byte_i[3:0]);
  assign accum_wide = WideW'(accum_q);
  assign max_wide   = WideW'(max_len_q);
  assign sat_len    = (accum_wide > WideW'(FrameLenMax)) ? FrameLenMax : accum_wide[15:0];

  always_comb begin
    phase_d  = phase_q;
    pwm_d    = pwm_q;
    fhs_d    = fhs_q;
    tds_d    = tds_q;
    accum_d  = accum_q;
    left_d   = left_q;
    clear    = 1'b0;
    result_o = '{valid: 1'b0, kind: KindData, data_byte: 8'h00, frame_length: sat_len};

    unique case (phase_q)
      PhLen, PhSkip: begin
        if (fhs_q) begin
          if ((byte_i != ByteHash) || (accum_wide > max_wide) || accum_q[LEN_WIDTH]) begin
            result_o.valid = 1'b1;
            result_o.kind  = KindReject;
            clear          = 1'b1;
          end else begin
            left_d  = accum_q[LEN_WIDTH-1:0];
            fhs_d   = 1'b0;
            tds_d   = 1'b0;
            pwm_d   = 1'b0;
            phase_d = (accum_q == '0) ? PhTail : PhPayload;
          end
        end else if (byte_i == ByteHash) begin
          fhs_d = 1'b1;
        end else if ((phase_q == PhLen) && is_digit) begin
          accum_d = (digit_sum > limit_x) ? AccW'(limit_x) : digit_sum[AccW-1:0];
        end else begin
          phase_d = PhSkip;
        end
      end
      PhPayload: begin
        left_d = left_q - LEN_WIDTH'(1);
        if (left_q == LEN_WIDTH'(1)) begin
          phase_d = PhTail;
          tds_d   = 1'b0;
          pwm_d   = 1'b0;
        end
        result_o.valid     = 1'b1;
        result_o.kind      = KindData;
        result_o.data_byte = byte_i;
      end
      PhTail: begin
        if ((byte_i == ByteTilde) && tds_q) begin
          result_o.valid = 1'b1;
          result_o.kind  = pwm_q ? KindAccept : KindReject;
          clear          = 1'b1;
        end else if ((byte_i == ByteDollar) && !tds_q) begin
          tds_d = 1'b1;
          pwm_d = 1'b1;
        end else begin
          pwm_d = 1'b0;
        end
      end
      default: begin
        if (phase_q != PhHunt) begin
          phase_d = PhHunt;
          fhs_d   = 1'b0;
          tds_d   = 1'b0;
          accum_d = '0;
          left_d  = '0;
        end
        if (byte_i == ByteDollar) begin
          pwm_d = 1'b1;
        end else if (byte_i == ByteHash) begin
          if (!(pwm_q && (phase_q == PhHunt))) begin
            result_o.valid        = 1'b1;
            result_o.kind         = KindReject;
            result_o.frame_length = '0;
            clear                 = 1'b1;
          end else begin
            phase_d = PhLen;
            pwm_d   = 1'b0;
            fhs_d   = 1'b0;
            accum_d = '0;
            left_d  = '0;
          end
        end else begin
          pwm_d = 1'b0;
        end
      end
    endcase

    if (clear) begin
      phase_d = PhHunt;
      pwm_d   = 1'b0;
      fhs_d   = 1'b0;
      tds_d   = 1'b0;
      accum_d = '0;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      pwm_q     <= 1'b0;
      fhs_q     <= 1'b0;
      tds_q     <= 1'b0;
      accum_q   <= '0;
      left_q    <= '0;
      max_len_q <= MaxLengthReset;
    end else begin
      if (step_i) begin
        phase_q <= phase_d;
        pwm_q   <= pwm_d;
        fhs_q   <= fhs_d;
        tds_q   <= tds_d;
        accum_q <= accum_d;
        left_q  <= left_d;
      end
      if (cfg_we_i) begin
        max_len_q <= cfg_max_length_i;
      end
    end
  end

endmodule

// File: hw/rtl/lpfd_out_stage.sv
module lpfd_out_stage import lpfd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  result_t     result_i,
  output logic        free_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] frame_length_o
);

  logic        vld_q, vld_d;
  kind_e       kind_q;
  logic [7:0]  data_q;
  logic [15:0] len_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      kind_q <= result_i.kind;
      data_q <= result_i.data_byte;
      len_q  <= result_i.frame_length;
    end
  end

  assign out_valid_o    = vld_q;
  assign kind_o         = kind_q;
  assign data_byte_o    = data_q;
  assign frame_length_o = len_q;

endmodule

// File: hw/rtl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer.
// Input channel: one received byte per beat on rx_byte_i (in_valid_i/in_ready_o).
// Frames look like "$#" <decimal length> "##" <payload> "$~".
// Output channel: one result per beat (out_valid_o/out_ready_i): kind_o is a
// payload byte (data_byte_o), a frame accept or a frame reject; frame_length_o
// carries the declared length, saturated to 16 bits.
// Config channel: cfg_valid_i/cfg_ready_o writes max_length (cfg_max_length_i);
// always ready, write it only while the block is idle.
// Path: a byte beat goes through the input register, the parse step, then
// the result register. Throughput: one byte per cycle unless a result waits
// on out_ready_i, set by the single parse step between the two registers.
// Stall: while a result waits, one more byte is taken into the input register;
// bytes that give no result still retire. Further bytes back-pressure.
// Reset: returns to header hunt, max_length to 1024, both registers empty.
module length_prefixed_frame_deframer import lpfd_pkg::*; #(
  parameter int unsigned LEN_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_max_length_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  data_byte_o,
  output logic [15:0] frame_length_o
);

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;
  logic       out_free;
  result_t    result;

  assign cfg_ready_o = 1'b1;
  assign advance     = byte_valid && (!result.valid || out_free);

  lpfd_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .rx_byte_i    (rx_byte_i),
    .advance_i    (advance),
    .byte_valid_o (byte_valid),
    .byte_o       (byte_q)
  );

  lpfd_parser #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_max_length_i (cfg_max_length_i),
    .step_i           (advance),
    .byte_i           (byte_q),
    .result_o         (result)
  );

  lpfd_out_stage u_out_stage (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (advance && result.valid),
    .result_i       (result),
    .free_o         (out_free),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .data_byte_o    (data_byte_o),
    .frame_length_o (frame_length_o)
  );

endmodule

// File: hw/rtl/lpfd_checker.sv
`include "length_prefixed_frame_deframer_macros.svh"

module lpfd_checker import lpfd_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  kind_o,
  input logic [7:0]  data_byte_o,
  input logic [15:0] frame_length_o
);

  // Hold a stalled result beat.
  `LPFD_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(kind_o) && $stable(data_byte_o) && $stable(frame_length_o), "stalled result changed")

  `LPFD_ASSERT(a_ctrl_data_zero, out_valid_o && (kind_o != KindData) |-> data_byte_o == 8'h00, "accept or reject carries a data byte")

  `LPFD_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o, "input blocked with empty output")

  `LPFD_ASSERT_RST(a_reset_empty, !rst_ni |=> !out_valid_o, "result valid after reset edge")

endmodule

bind length_prefixed_frame_deframer lpfd_checker u_checker (.*);
